// File: hdl/bpp_pkg.sv
// ----------------------------------------------------------------------------
// bpp_pkg
// Shared types, constants and the quality-to-error-probability ROM for the
// base probability profile.
// ----------------------------------------------------------------------------
package bpp_pkg;

    // fixed field widths
    localparam int COLUMN_W      = 12;
    localparam int BASE_W        = 8;
    localparam int QUAL_W        = 7;
    localparam int SUM_W         = 40;
    localparam int FRACTION_BITS = 20;

    // command codes
    localparam logic CMD_ACCUMULATE = 1'b0;
    localparam logic CMD_READ       = 1'b1;

    // base characters
    localparam logic [BASE_W-1:0] CHAR_GAP = 8'h2D;
    localparam logic [BASE_W-1:0] CHAR_N   = 8'h4E;
    localparam logic [BASE_W-1:0] CHAR_A   = 8'h41;
    localparam logic [BASE_W-1:0] CHAR_C   = 8'h43;
    localparam logic [BASE_W-1:0] CHAR_G   = 8'h47;
    localparam logic [BASE_W-1:0] CHAR_T   = 8'h54;

    // quality clamp window
    localparam logic [QUAL_W-1:0] QUAL_MIN = 7'd33;
    localparam logic [QUAL_W-1:0] QUAL_MAX = 7'd126;

    // floor(x / 3) as (x * THIRD_MUL) >> THIRD_SHIFT, exact for x below 2^21
    localparam int                   THIRD_SHIFT = 22;
    localparam logic [FRACTION_BITS:0] THIRD_MUL = 21'd1398102;

    typedef struct packed {
        logic                command;
        logic [COLUMN_W-1:0] column;
        logic [BASE_W-1:0]   base_char;
        logic [QUAL_W-1:0]   quality_char;
        logic                repeated_read;
    } t_in_item;

    typedef struct packed {
        logic [SUM_W-1:0] total_a;
        logic [SUM_W-1:0] total_c;
        logic [SUM_W-1:0] total_g;
        logic [SUM_W-1:0] total_t;
    } t_out_item;

    // error probability 10^(-(q-30)/10) rounded to FRACTION_BITS bits,
    // q already clamped to 33..126; zero above q = 93
    function automatic logic [FRACTION_BITS-1:0] err_prob(input logic [QUAL_W-1:0] q);
        logic [FRACTION_BITS-1:0] p;
        case (q)
            7'd33: p = 20'd525533;
            7'd34: p = 20'd417446;
            7'd35: p = 20'd331589;
            7'd36: p = 20'd263390;
            7'd37: p = 20'd209218;
            7'd38: p = 20'd166188;
            7'd39: p = 20'd132008;
            7'd40: p = 20'd104858;
            7'd41: p = 20'd83291;
            7'd42: p = 20'd66161;
            7'd43: p = 20'd52553;
            7'd44: p = 20'd41745;
            7'd45: p = 20'd33159;
            7'd46: p = 20'd26339;
            7'd47: p = 20'd20922;
            7'd48: p = 20'd16619;
            7'd49: p = 20'd13201;
            7'd50: p = 20'd10486;
            7'd51: p = 20'd8329;
            7'd52: p = 20'd6616;
            7'd53: p = 20'd5255;
            7'd54: p = 20'd4174;
            7'd55: p = 20'd3316;
            7'd56: p = 20'd2634;
            7'd57: p = 20'd2092;
            7'd58: p = 20'd1662;
            7'd59: p = 20'd1320;
            7'd60: p = 20'd1049;
            7'd61: p = 20'd833;
            7'd62: p = 20'd662;
            7'd63: p = 20'd526;
            7'd64: p = 20'd417;
            7'd65: p = 20'd332;
            7'd66: p = 20'd263;
            7'd67: p = 20'd209;
            7'd68: p = 20'd166;
            7'd69: p = 20'd132;
            7'd70: p = 20'd105;
            7'd71: p = 20'd83;
            7'd72: p = 20'd66;
            7'd73: p = 20'd53;
            7'd74: p = 20'd42;
            7'd75: p = 20'd33;
            7'd76: p = 20'd26;
            7'd77: p = 20'd21;
            7'd78: p = 20'd17;
            7'd79: p = 20'd13;
            7'd80: p = 20'd10;
            7'd81: p = 20'd8;
            7'd82: p = 20'd7;
            7'd83: p = 20'd5;
            7'd84: p = 20'd4;
            7'd85: p = 20'd3;
            7'd86: p = 20'd3;
            7'd87: p = 20'd2;
            7'd88: p = 20'd2;
            7'd89: p = 20'd1;
            7'd90: p = 20'd1;
            7'd91: p = 20'd1;
            7'd92: p = 20'd1;
            7'd93: p = 20'd1;
            default: p = '0;
        endcase
        return p;
    endfunction

endpackage

// File: hdl/bpp_if.sv
// ----------------------------------------------------------------------------
// bpp_if
// Valid/ready channels carrying profile commands in and column totals out.
// ----------------------------------------------------------------------------
interface bpp_in_if;
    logic              valid;
    logic              ready;
    bpp_pkg::t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface bpp_out_if;
    logic               valid;
    logic               ready;
    bpp_pkg::t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: hdl/base_probability_profile.sv
// ----------------------------------------------------------------------------
// base_probability_profile
// Per-column A/C/G/T probability accumulator held in one row-wide memory.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries commands. An accumulate adds the Q1.20 probabilities of one
//   aligned base to its column's four saturating 40-bit sums; a read returns
//   that column's four totals on o_out. Columns at or above COLUMNS are
//   ignored on accumulate and read back as zero.
//   Throughput: one command per cycle. Each item does one read-modify-write
//   of its column row; a write that lands on the edge of the next read of
//   the same column is forwarded, so equal columns back to back need no
//   bubble.
//   Read path: a read passes the stage 1 registers, then the stage 2
//   registers with its memory row, and then loads the output register.
//   Reset: a clearing pass zeroes every row of the profile one row per cycle;
//   i_in.ready stays low until it ends.
//   Stall: a finished result waits in the output register while accumulates
//   keep flowing; only a second read that reaches the write-back stage while
//   the result still waits holds the pipeline and drops i_in.ready.
// ----------------------------------------------------------------------------
module base_probability_profile #(
    parameter int COLUMNS = 4096
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    bpp_in_if.sink           i_in,
    bpp_out_if.source        o_out
);

    localparam int AW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int CW = bpp_pkg::COLUMN_W;
    localparam int FB = bpp_pkg::FRACTION_BITS;
    localparam int SW = bpp_pkg::SUM_W;
    localparam int VW = FB + 1;
    localparam int PW = 2 * VW;

    // contribution kinds
    localparam logic [1:0] KIND_SKIP    = 2'd0;
    localparam logic [1:0] KIND_QUARTER = 2'd1;
    localparam logic [1:0] KIND_UNKNOWN = 2'd2;
    localparam logic [1:0] KIND_HIT     = 2'd3;

    localparam logic [VW-1:0] ONE     = VW'(1) << FB;
    localparam logic [VW-1:0] QUARTER = VW'(1) << (FB - 2);
    localparam logic [AW-1:0] LAST    = AW'(COLUMNS - 1);

    typedef logic [3:0][SW-1:0] t_row;
    typedef logic [3:0][VW-1:0] t_lanes;

    // profile store, one row holds the four sums of a column
    t_row            r_mem [0:COLUMNS-1];
    t_row            r_rd;

    // clearing pass
    logic            r_clearing;
    logic [AW-1:0]   r_clr_addr;

    // stage 1: decoded item and rom lookup
    logic            r_s1_valid;
    logic            r_s1_cmd;
    logic [AW-1:0]   r_s1_addr;
    logic            r_s1_col_ok;
    logic [1:0]      r_s1_kind;
    logic [1:0]      r_s1_hit;
    logic            r_s1_rep;
    logic [FB-1:0]   r_s1_p;

    // stage 2: contributions and memory row
    logic            r_s2_valid;
    logic            r_s2_cmd;
    logic [AW-1:0]   r_s2_addr;
    logic            r_s2_col_ok;
    logic            r_s2_write;
    t_lanes          r_s2_v;
    logic            r_s2_fwd;
    t_row            r_fwd_row;

    // output register
    logic                 r_out_valid;
    bpp_pkg::t_out_item   r_out;

    // next values and datapath
    logic                 accept;
    logic                 stall;
    logic [AW+CW-1:0]     col_ext;
    logic                 n_col_ok;
    logic [1:0]           n_kind;
    logic [1:0]           n_hit;
    logic [6:0]           q_clamp;
    logic [FB:0]          p_inc;
    logic [PW-1:0]        third_prod;
    logic [VW-1:0]        third;
    logic [VW:0]          half_tmp;
    t_lanes               n_v;
    t_row                 base_row;
    t_row                 sum_row;
    logic [SW:0]          sum_wide;
    logic                 wr_pipe;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    t_row                 wr_data;
    logic                 out_load;

    // handshake control
    assign accept   = i_in.valid && i_in.ready;
    assign stall    = r_s2_valid && (r_s2_cmd == bpp_pkg::CMD_READ)
                      && r_out_valid && !o_out.ready;
    assign i_in.ready = !r_clearing && !stall;
    assign out_load = r_s2_valid && (r_s2_cmd == bpp_pkg::CMD_READ) && !stall;

    // column range check, base decode and quality clamp
    always_comb begin
        col_ext  = {{AW{1'b0}}, i_in.payload.column};
        n_col_ok = col_ext < (AW + CW)'(COLUMNS);
        n_hit    = 2'd0;
        case (i_in.payload.base_char)
            bpp_pkg::CHAR_GAP: n_kind = KIND_SKIP;
            bpp_pkg::CHAR_N:   n_kind = KIND_QUARTER;
            bpp_pkg::CHAR_A: begin
                n_kind = KIND_HIT;
                n_hit  = 2'd0;
            end
            bpp_pkg::CHAR_C: begin
                n_kind = KIND_HIT;
                n_hit  = 2'd1;
            end
            bpp_pkg::CHAR_G: begin
                n_kind = KIND_HIT;
                n_hit  = 2'd2;
            end
            bpp_pkg::CHAR_T: begin
                n_kind = KIND_HIT;
                n_hit  = 2'd3;
            end
            default: n_kind = KIND_UNKNOWN;
        endcase
        if (i_in.payload.quality_char < bpp_pkg::QUAL_MIN) begin
            q_clamp = bpp_pkg::QUAL_MIN;
        end else if (i_in.payload.quality_char > bpp_pkg::QUAL_MAX) begin
            q_clamp = bpp_pkg::QUAL_MAX;
        end else begin
            q_clamp = i_in.payload.quality_char;
        end
    end

    // stage 1 registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!stall) begin
            r_s1_valid <= accept;
        end
        if (accept) begin
            r_s1_cmd    <= i_in.payload.command;
            r_s1_addr   <= col_ext[AW-1:0];
            r_s1_col_ok <= n_col_ok;
            r_s1_kind   <= n_kind;
            r_s1_hit    <= n_hit;
            r_s1_rep    <= i_in.payload.repeated_read;
            r_s1_p      <= bpp_pkg::err_prob(q_clamp);
        end
    end

    // one third of p by reciprocal multiply, then per-lane contributions
    always_comb begin
        p_inc      = {1'b0, r_s1_p} + (FB + 1)'(1);
        third_prod = PW'(p_inc) * PW'(bpp_pkg::THIRD_MUL);
        third      = VW'(third_prod >> bpp_pkg::THIRD_SHIFT);
        half_tmp   = '0;
        for (int j = 0; j < 4; j++) begin
            case (r_s1_kind)
                KIND_SKIP:    n_v[j] = '0;
                KIND_QUARTER: n_v[j] = QUARTER;
                KIND_UNKNOWN: n_v[j] = third;
                KIND_HIT:     n_v[j] = (r_s1_hit == 2'(j)) ? (ONE - VW'(r_s1_p)) : third;
                default:      n_v[j] = '0;
            endcase
            if (r_s1_rep) begin
                half_tmp = {1'b0, n_v[j]} + (VW + 1)'(1);
                n_v[j]   = half_tmp[VW:1];
            end
        end
    end

    // stage 2 registers and forwarding capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (!stall) begin
            r_s2_valid <= r_s1_valid;
        end
        if (!stall && r_s1_valid) begin
            r_s2_cmd    <= r_s1_cmd;
            r_s2_addr   <= r_s1_addr;
            r_s2_col_ok <= r_s1_col_ok;
            r_s2_write  <= (r_s1_cmd == bpp_pkg::CMD_ACCUMULATE) && r_s1_col_ok
                           && (r_s1_kind != KIND_SKIP);
            r_s2_v      <= n_v;
            r_s2_fwd    <= wr_pipe && (r_s2_addr == r_s1_addr);
            r_fwd_row   <= sum_row;
        end
    end

    // memory read of the stage 1 column
    always_ff @(posedge i_clk) begin
        if (!stall && r_s1_valid && r_s1_col_ok) begin
            r_rd <= r_mem[r_s1_addr];
        end
    end

    // saturating add on the forwarded or stored row
    always_comb begin
        base_row = r_s2_fwd ? r_fwd_row : r_rd;
        sum_wide = '0;
        for (int j = 0; j < 4; j++) begin
            sum_wide   = {1'b0, base_row[j]} + (SW + 1)'(r_s2_v[j]);
            sum_row[j] = sum_wide[SW] ? {SW{1'b1}} : sum_wide[SW-1:0];
        end
    end

    // write port shared by clearing pass and write-back
    assign wr_pipe = r_s2_valid && r_s2_write;
    assign wr_en   = r_clearing || wr_pipe;
    assign wr_addr = r_clearing ? r_clr_addr : r_s2_addr;
    assign wr_data = r_clearing ? '0 : sum_row;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    // clearing pass after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == LAST) begin
                r_clearing <= 1'b0;
            end else begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (out_load) begin
            if (r_s2_col_ok) begin
                r_out.total_a <= base_row[0];
                r_out.total_c <= base_row[1];
                r_out.total_g <= base_row[2];
                r_out.total_t <= base_row[3];
            end else begin
                r_out <= '0;
            end
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    // no item may be in flight while the profile is being cleared
    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !r_s1_valid && !r_s2_valid)
        else $error("item in pipeline during clearing pass");

    // write-back stays inside the profile
    a_wr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_pipe |-> r_s2_col_ok && (r_s2_addr <= LAST))
        else $error("write-back outside the profile");

    // a forwarded row must come from a write on the previous edge
    a_fwd_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid && r_s2_fwd && !$past(stall) |-> $past(wr_pipe))
        else $error("forward flag without a preceding write-back");

    // a new result only follows a read command in stage 2
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !$past(r_out_valid)
        |-> $past(r_s2_valid && (r_s2_cmd == bpp_pkg::CMD_READ)))
        else $error("result without a read command");

endmodule

// File: dv/bpp_profile_check.sv
// ----------------------------------------------------------------------------
// bpp_profile_check
// Watches the command and totals channels of the base probability profile,
// keeps its own copy of the four per-column sums, predicts the totals of
// every read and compares each returned result field by field.
// ----------------------------------------------------------------------------
module bpp_profile_check #(
    parameter int COLUMNS = 4096
) (
    input  logic i_clk,
    input  logic i_rst_n,
    bpp_in_if    i_cmd,
    bpp_out_if   i_totals,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked
);

    localparam int              FB      = bpp_pkg::FRACTION_BITS;
    localparam int              SW      = bpp_pkg::SUM_W;
    localparam int              VW      = FB + 1;
    localparam logic [VW-1:0]   UNIT    = VW'(1) << FB;
    localparam logic [VW-1:0]   QUARTER = VW'(1) << (FB - 2);
    localparam longint unsigned DEC_ONE = 64'd1000000000000000000;

    // predicted profile, one row of four sums per column
    bpp_pkg::t_out_item profile [COLUMNS];
    // column totals still owed by the block, oldest first
    bpp_pkg::t_out_item owed_totals [$];
    int                 fail_count;
    int                 checked;

    // 10^(-b/10) scaled by 1e18
    function automatic longint unsigned decade_frac(input int b);
        case (b)
            0:       return 64'd1000000000000000000;
            1:       return 64'd794328234724281502;
            2:       return 64'd630957344480193250;
            3:       return 64'd501187233627272285;
            4:       return 64'd398107170553497251;
            5:       return 64'd316227766016837933;
            6:       return 64'd251188643150958011;
            7:       return 64'd199526231496887960;
            8:       return 64'd158489319246111349;
            default: return 64'd125892541179416721;
        endcase
    endfunction

    // error probability of a clamped quality, rounded to the fraction width
    function automatic logic [FB-1:0] phred_error(input logic [bpp_pkg::QUAL_W-1:0] q);
        longint unsigned den;
        longint unsigned scaled;
        longint unsigned rem;
        longint unsigned frac;
        int              e;
        e   = int'(q) - 30;
        den = 1;
        for (int i = 0; i < e / 10; i++)
            den = den * 10;
        scaled = (decade_frac(e % 10) + den / 2) / den;
        frac   = scaled / DEC_ONE;
        rem    = scaled % DEC_ONE;
        // binary long division of the decimal remainder
        for (int i = 0; i < FB; i++) begin
            rem  = rem << 1;
            frac = frac << 1;
            if (rem >= DEC_ONE) begin
                frac = frac | 1;
                rem  = rem - DEC_ONE;
            end
        end
        if (2 * rem >= DEC_ONE)
            frac = frac + 1;
        return frac[FB-1:0];
    endfunction

    function automatic logic [SW-1:0] sat_add(input logic [SW-1:0] s,
                                              input logic [VW-1:0] v);
        logic [SW:0] t;
        t = {1'b0, s} + (SW + 1)'(v);
        return t[SW] ? {SW{1'b1}} : t[SW-1:0];
    endfunction

    // update the profile for one accepted command, queue totals for a read
    function automatic void apply_command(input bpp_pkg::t_in_item c);
        logic [VW-1:0]              share [4];
        logic [FB-1:0]              p;
        logic [bpp_pkg::QUAL_W-1:0] q;
        bpp_pkg::t_out_item         row;
        if (c.command == bpp_pkg::CMD_READ) begin
            owed_totals.push_back(c.column < COLUMNS ? profile[c.column] : '0);
            return;
        end
        if (c.column >= COLUMNS || c.base_char == bpp_pkg::CHAR_GAP)
            return;
        if (c.base_char == bpp_pkg::CHAR_N) begin
            for (int j = 0; j < 4; j++)
                share[j] = QUARTER;
        end else begin
            q = c.quality_char;
            if (q < bpp_pkg::QUAL_MIN)
                q = bpp_pkg::QUAL_MIN;
            if (q > bpp_pkg::QUAL_MAX)
                q = bpp_pkg::QUAL_MAX;
            p = phred_error(q);
            for (int j = 0; j < 4; j++)
                share[j] = ({1'b0, p} + VW'(1)) / VW'(3);
            // a called base keeps 1-p, unknown characters spread p/3 only
            case (c.base_char)
                bpp_pkg::CHAR_A: share[0] = UNIT - VW'(p);
                bpp_pkg::CHAR_C: share[1] = UNIT - VW'(p);
                bpp_pkg::CHAR_G: share[2] = UNIT - VW'(p);
                bpp_pkg::CHAR_T: share[3] = UNIT - VW'(p);
                default: ;
            endcase
        end
        // repeated read counts half, rounded up
        if (c.repeated_read) begin
            for (int j = 0; j < 4; j++)
                share[j] = (share[j] + VW'(1)) >> 1;
        end
        row = profile[c.column];
        row.total_a = sat_add(row.total_a, share[0]);
        row.total_c = sat_add(row.total_c, share[1]);
        row.total_g = sat_add(row.total_g, share[2]);
        row.total_t = sat_add(row.total_t, share[3]);
        profile[c.column] = row;
    endfunction

    function automatic void compare_field(input string name, input logic [SW-1:0] want,
                                          input logic [SW-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    function automatic void check_totals(input bpp_pkg::t_out_item got);
        bpp_pkg::t_out_item want;
        if (owed_totals.size() == 0) begin
            $error("unexpected totals transfer: a=%0d c=%0d g=%0d t=%0d",
                   got.total_a, got.total_c, got.total_g, got.total_t);
            fail_count++;
            return;
        end
        want = owed_totals.pop_front();
        compare_field("total_a", want.total_a, got.total_a);
        compare_field("total_c", want.total_c, got.total_c);
        compare_field("total_g", want.total_g, got.total_g);
        compare_field("total_t", want.total_t, got.total_t);
        checked++;
    endfunction

    initial begin
        fail_count = 0;
        checked    = 0;
    end

    // sample both channels at the clock edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < COLUMNS; k++)
                profile[k] = '0;
            owed_totals.delete();
        end else begin
            if (i_cmd.valid && i_cmd.ready)
                apply_command(i_cmd.payload);
            if (i_totals.valid && i_totals.ready)
                check_totals(i_totals.payload);
        end
        o_fail_count <= fail_count;
        o_pending    <= owed_totals.size();
        o_checked    <= checked;
    end

endmodule

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the base probability profile: directed corner
// commands, random accumulate and read traffic over hot and random columns
// with random gaps and stalls, then a short full-rate burst into one column.
// ----------------------------------------------------------------------------
module tb;

    typedef logic [bpp_pkg::COLUMN_W-1:0] t_column;
    typedef logic [bpp_pkg::BASE_W-1:0]   t_base;
    typedef logic [bpp_pkg::QUAL_W-1:0]   t_qual;

    localparam int      COLUMNS      = 4096;
    localparam int      RANDOM_ITEMS = 700;
    localparam int      BURST_ADDS   = 24;
    localparam int      DRAIN_CYCLES = 16;
    localparam longint  CYCLE_LIMIT  = 400000;
    localparam t_column BURST_COLUMN = 12'hAAA;
    localparam t_column LAST_COLUMN  = t_column'(COLUMNS - 1);

    logic   i_clk;
    logic   i_rst_n;
    bit     pace_gaps = 1'b1;
    longint cycle_count = 0;
    int     accum_sent = 0;
    int     reads_sent = 0;
    int     fail_count;
    int     pending;
    int     checked;

    bpp_in_if  in_ch ();
    bpp_out_if out_ch ();

    base_probability_profile #(
        .COLUMNS (COLUMNS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    bpp_profile_check #(
        .COLUMNS (COLUMNS)
    ) profile_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (in_ch),
        .i_totals     (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d totals still owed", cycle_count, pending);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic bpp_pkg::t_in_item make_item(input logic cmd, input t_column col,
                                                    input t_base base,
                                                    input t_qual qual, input logic rep);
        bpp_pkg::t_in_item it;
        it.command       = cmd;
        it.column        = col;
        it.base_char     = base;
        it.quality_char  = qual;
        it.repeated_read = rep;
        return it;
    endfunction

    // random command, biased to a few hot columns so reads see history
    function automatic bpp_pkg::t_in_item random_item();
        bpp_pkg::t_in_item it;
        int                pick;
        it.command = ($urandom_range(0, 99) < 30) ? bpp_pkg::CMD_READ
                                                  : bpp_pkg::CMD_ACCUMULATE;
        if ($urandom_range(0, 99) < 60) begin
            case ($urandom_range(0, 7))
                0:       it.column = '0;
                1:       it.column = 12'd1;
                2:       it.column = 12'd2;
                3:       it.column = 12'd1365;
                4:       it.column = 12'd2047;
                5:       it.column = 12'd2048;
                6:       it.column = LAST_COLUMN - t_column'(1);
                default: it.column = LAST_COLUMN;
            endcase
        end else begin
            it.column = t_column'($urandom_range(0, COLUMNS - 1));
        end
        pick = $urandom_range(0, 99);
        if (pick < 18)
            it.base_char = bpp_pkg::CHAR_A;
        else if (pick < 36)
            it.base_char = bpp_pkg::CHAR_C;
        else if (pick < 54)
            it.base_char = bpp_pkg::CHAR_G;
        else if (pick < 72)
            it.base_char = bpp_pkg::CHAR_T;
        else if (pick < 80)
            it.base_char = bpp_pkg::CHAR_N;
        else if (pick < 86)
            it.base_char = bpp_pkg::CHAR_GAP;
        else if (pick < 92) begin
            case ($urandom_range(0, 4))
                0:       it.base_char = "a";
                1:       it.base_char = "c";
                2:       it.base_char = "g";
                3:       it.base_char = "t";
                default: it.base_char = "n";
            endcase
        end else
            it.base_char = t_base'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < 85)
            it.quality_char = t_qual'($urandom_range(bpp_pkg::QUAL_MIN, bpp_pkg::QUAL_MAX));
        else
            it.quality_char = t_qual'($urandom_range(0, 127));
        it.repeated_read = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // present one command and hold it until the transfer
    task automatic push_item(input bpp_pkg::t_in_item item);
        int gap;
        gap = pace_gaps ? gap_len() : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.payload <= item;
        do @(posedge i_clk); while (!in_ch.ready);
        if (item.command == bpp_pkg::CMD_READ)
            reads_sent++;
        else
            accum_sent++;
    endtask

    // totals sink with random stalls
    initial begin
        int n;
        forever begin
            if (pace_gaps) begin
                n = gap_len();
                if (n > 0) begin
                    out_ch.ready <= 1'b0;
                    repeat (n) @(posedge i_clk);
                end
                out_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.payload <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed corners: clamp edges, every base class, halving, end columns
        push_item(make_item(bpp_pkg::CMD_READ,       '0, bpp_pkg::CHAR_A, 7'd40, 1'b0));
        push_item(make_item(bpp_pkg::CMD_ACCUMULATE, '0, bpp_pkg::CHAR_A,
                            bpp_pkg::QUAL_MIN, 1'b0));
        push_item(make_item(bpp_pkg::CMD_ACCUMULATE, '0, bpp_pkg::CHAR_C,
                            bpp_pkg::QUAL_MAX, 1'b0));
        push_item(make_item(bpp_pkg::CMD_ACCUMULATE, '0, bpp_pkg::CHAR_G,   7'd0,   1'b1));
        push_item(make_item(bpp_pkg::CMD_ACCUMULATE, '0, bpp_pkg::CHAR_T,   7'd127, 1'b1));
        push_item(make_item(bpp_pkg::CMD_ACCUMULATE, '0, bpp_pkg::CHAR_G,   7'd32,  1'b0));
        push_item(make_item(bpp_pkg::CMD_ACCUMULATE, '0, bpp_pkg::CHAR_N,   7'd0,   1'b0));
        push_item(make_item(bpp_pkg::CMD_ACCUMULATE, '0, bpp_pkg::CHAR_N,   7'd127, 1'b1));
        push_item(make_item(bpp_pkg::CMD_ACCUMULATE, '0, bpp_pkg::CHAR_GAP, 7'd33,  1'b0));
        push_item(make_item(bpp_pkg::CMD_ACCUMULATE, '0, "a",               7'd40,  1'b0));
        push_item(make_item(bpp_pkg::CMD_ACCUMULATE, '0, 8'hFF,             7'd60,  1'b1));
        push_item(make_item(bpp_pkg::CMD_READ,       '0, 8'h00,             7'd0,   1'b0));
        push_item(make_item(bpp_pkg::CMD_ACCUMULATE, LAST_COLUMN, 8'h00, 7'd93, 1'b0));
        push_item(make_item(bpp_pkg::CMD_ACCUMULATE, LAST_COLUMN, bpp_pkg::CHAR_A,
                            7'd94, 1'b1));
        push_item(make_item(bpp_pkg::CMD_ACCUMULATE, LAST_COLUMN, bpp_pkg::CHAR_T,
                            7'd34, 1'b1));
        push_item(make_item(bpp_pkg::CMD_ACCUMULATE, LAST_COLUMN, bpp_pkg::CHAR_C,
                            7'd89, 1'b0));
        push_item(make_item(bpp_pkg::CMD_READ, LAST_COLUMN, 8'hFF, 7'd127, 1'b1));
        push_item(make_item(bpp_pkg::CMD_READ, LAST_COLUMN, bpp_pkg::CHAR_N, 7'd0, 1'b0));
        push_item(make_item(bpp_pkg::CMD_READ, '0, bpp_pkg::CHAR_GAP, 7'd1, 1'b1));

        // random traffic, pacing switched on and off in stretches
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k % 50 == 0)
                pace_gaps <= ($urandom_range(0, 9) < 7);
            push_item(random_item());
        end

        // full-rate burst into one column, same-column updates back to back
        pace_gaps <= 1'b0;
        for (int k = 0; k < BURST_ADDS; k++) begin
            if (k == BURST_ADDS / 2)
                push_item(make_item(bpp_pkg::CMD_READ, BURST_COLUMN, bpp_pkg::CHAR_C,
                                    7'd45, 1'b0));
            push_item(make_item(bpp_pkg::CMD_ACCUMULATE, BURST_COLUMN, bpp_pkg::CHAR_C,
                                7'd45, k[0]));
        end
        push_item(make_item(bpp_pkg::CMD_READ, BURST_COLUMN, bpp_pkg::CHAR_C, 7'd45, 1'b0));
        in_ch.valid <= 1'b0;

        // let owed totals arrive, then watch for stray transfers
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d accumulates and %0d reads, %0d column totals compared",
                 accum_sent, reads_sent, checked);
        $display("covered quality clamping, all base classes, halving and same-column bursts");
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
